// File: rtl/pidbb_pkg.sv
// pidbb_pkg: widths, codes, shared types and the saturation helper for the
// heater controller with bang-bang zone. No dependencies.
package pidbb_pkg;

	localparam int TEMP_W   = 16;            // Q11.4 temperature
	localparam int ERR_W    = TEMP_W + 1;    // error and sample difference
	localparam int GAIN_W   = 16;            // Q8.8 gains, Q0.16 smoothing
	localparam int RANGE_W  = 15;
	localparam int DRIVE_W  = 8;
	localparam int ACC_W    = 32;            // integral and derivative state
	localparam int PE_W     = GAIN_W + 1 + ERR_W;
	localparam int OUT_FRAC = 12;            // P, I, D and their sum are Q.12
	localparam int SUM_W    = GAIN_W + 1 + ACC_W + 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 16;

	localparam logic signed [63:0] ACC_MAX = 64'sd2147483647;
	localparam logic signed [63:0] ACC_MIN = -64'sd2147483648;

	typedef enum logic [1:0] {
		REGION_PID     = 2'd0,
		REGION_FULL_ON = 2'd1,
		REGION_OFF     = 2'd2,
		REGION_CLAMPED = 2'd3
	} region_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN    = 3'd0,
		CFG_INTEG_GAIN   = 3'd1,
		CFG_DERIV_GAIN   = 3'd2,
		CFG_DERIV_SMOOTH = 3'd3,
		CFG_TARGET_TEMP  = 3'd4,
		CFG_FUNC_RANGE   = 3'd5,
		CFG_FULL_DRIVE   = 3'd6,
		CFG_DRIVE_MAX    = 3'd7
	} cfg_idx_t;

	// Request as it leaves the derivative stage
	typedef struct packed {
		logic signed [ERR_W-1:0] err;
		logic signed [PE_W-1:0]  pe;
		logic signed [ACC_W-1:0] d;
		logic                    far_high;
		logic                    far_low;
	} law_in_t;

	typedef struct packed {
		logic [DRIVE_W-1:0]      drive;
		region_t                 region;
		logic signed [ACC_W-1:0] integral;
		logic                    reentry;
	} law_out_t;

	function automatic logic signed [ACC_W-1:0] sat32(input logic signed [63:0] v);
		if (v > ACC_MAX) begin
			return ACC_MAX[ACC_W-1:0];
		end else if (v < ACC_MIN) begin
			return ACC_MIN[ACC_W-1:0];
		end
		return v[ACC_W-1:0];
	endfunction

endpackage

// File: rtl/pidbb_deriv.sv
// pidbb_deriv: one update of the filtered derivative on the measurement.
// Depends on pidbb_pkg.
module pidbb_deriv (
	input  logic        [pidbb_pkg::GAIN_W-1:0] deriv_gain_scaled,
	input  logic        [pidbb_pkg::GAIN_W-1:0] deriv_smoothing,
	input  logic signed [pidbb_pkg::ERR_W-1:0]  diff,
	input  logic signed [pidbb_pkg::ACC_W-1:0]  d_prev,
	output logic signed [pidbb_pkg::ACC_W-1:0]  d_next
);

	logic signed [pidbb_pkg::GAIN_W:0]                      smooth_w;
	logic signed [pidbb_pkg::GAIN_W:0]                      gain_w;
	logic signed [pidbb_pkg::GAIN_W+pidbb_pkg::ACC_W:0]     decay_prod;
	logic signed [pidbb_pkg::ACC_W+pidbb_pkg::GAIN_W-16:0]  decayed;
	logic signed [pidbb_pkg::GAIN_W+pidbb_pkg::ERR_W:0]     fresh;

	always_comb begin
		smooth_w   = $signed({1'b0, deriv_smoothing});
		gain_w     = $signed({1'b0, deriv_gain_scaled});
		decay_prod = smooth_w * d_prev;
		// floor division by 2^16
		decayed    = $signed(decay_prod[pidbb_pkg::GAIN_W+pidbb_pkg::ACC_W:16]);
		fresh      = gain_w * diff;
		d_next     = pidbb_pkg::sat32(64'(decayed) + 64'(fresh));
	end

endmodule

// File: rtl/pidbb_law.sv
// pidbb_law: zone selection and PID output law with conditional
// un-integration and integral saturation. Depends on pidbb_pkg.
module pidbb_law (
	input  pidbb_pkg::law_in_t                      req,
	input  logic signed [pidbb_pkg::ACC_W-1:0]       integral,
	input  logic                                     reentry,
	input  logic        [pidbb_pkg::GAIN_W-1:0]      integ_gain,
	input  logic        [pidbb_pkg::DRIVE_W-1:0]     full_drive,
	input  logic        [pidbb_pkg::DRIVE_W-1:0]     drive_max,
	output pidbb_pkg::law_out_t                      res
);

	logic signed [pidbb_pkg::ACC_W-1:0]            base;
	logic signed [pidbb_pkg::ACC_W-1:0]            cand;
	logic signed [pidbb_pkg::GAIN_W:0]             ig_w;
	logic signed [pidbb_pkg::GAIN_W+pidbb_pkg::ACC_W:0] ic;
	logic signed [pidbb_pkg::SUM_W-1:0]            sum;
	logic signed [pidbb_pkg::SUM_W-1:0]            top;

	always_comb begin
		// clear the integral when the band is re-entered
		base = reentry ? '0 : integral;
		cand = pidbb_pkg::sat32(64'(base) + 64'(req.err));
		ig_w = $signed({1'b0, integ_gain});
		ic   = ig_w * cand;
		sum  = pidbb_pkg::SUM_W'(req.pe) + pidbb_pkg::SUM_W'(ic)
			- pidbb_pkg::SUM_W'(req.d);
		top  = {{(pidbb_pkg::SUM_W-pidbb_pkg::DRIVE_W-pidbb_pkg::OUT_FRAC){1'b0}},
			drive_max, {pidbb_pkg::OUT_FRAC{1'b0}}};

		res.drive    = '0;
		res.region   = pidbb_pkg::REGION_PID;
		res.integral = integral;
		res.reentry  = reentry;
		if (req.far_high) begin
			res.drive   = full_drive;
			res.region  = pidbb_pkg::REGION_FULL_ON;
			res.reentry = 1'b1;
		end else if (req.far_low) begin
			res.region  = pidbb_pkg::REGION_OFF;
			res.reentry = 1'b1;
		end else begin
			res.reentry = 1'b0;
			if (sum > top) begin
				res.drive    = drive_max;
				res.region   = pidbb_pkg::REGION_CLAMPED;
				res.integral = (req.err > 0) ? base : cand;
			end else if (sum < 0) begin
				res.region   = pidbb_pkg::REGION_CLAMPED;
				res.integral = (req.err < 0) ? base : cand;
			end else begin
				res.drive    = sum[pidbb_pkg::OUT_FRAC +: pidbb_pkg::DRIVE_W];
				res.integral = cand;
			end
		end
	end

endmodule

// File: rtl/pid_with_bang_bang_zone.sv
// pid_with_bang_bang_zone: heater controller, one drive value per temperature request.
// Stages: the sample register, the derivative stage and the output register; throughput one request
// per cycle, back to back, while out_ready is high.
// The output stage closes the integral loop (add, 17x32 multiply, sum, compare) with integral_q as its only register.
// Reset: configuration registers return to their defaults, integral/derivative/previous sample clear,
// the re-entry flag drops and the pipeline empties. Depends on pidbb_pkg, pidbb_deriv, pidbb_law.
module pid_with_bang_bang_zone (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pidbb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidbb_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [pidbb_pkg::TEMP_W-1:0]   measured_temp,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [pidbb_pkg::DRIVE_W-1:0]         drive,
	output logic [1:0]                            region
);

	// Configuration registers
	logic        [pidbb_pkg::GAIN_W-1:0]  prop_gain_q;
	logic        [pidbb_pkg::GAIN_W-1:0]  integ_gain_q;
	logic        [pidbb_pkg::GAIN_W-1:0]  deriv_gain_q;
	logic        [pidbb_pkg::GAIN_W-1:0]  deriv_smooth_q;
	logic signed [pidbb_pkg::TEMP_W-1:0]  target_q;
	logic        [pidbb_pkg::RANGE_W-1:0] range_q;
	logic        [pidbb_pkg::DRIVE_W-1:0] full_drive_q;
	logic        [pidbb_pkg::DRIVE_W-1:0] drive_max_q;

	// Controller state
	logic signed [pidbb_pkg::TEMP_W-1:0]  prev_temp_q;
	logic signed [pidbb_pkg::ACC_W-1:0]   deriv_q;
	logic signed [pidbb_pkg::ACC_W-1:0]   integral_q;
	logic                                 reentry_q;

	// Stage 1: captured sample, error and difference to the previous sample
	logic                                 valid_s1;
	logic signed [pidbb_pkg::ERR_W-1:0]   err_s1;
	logic signed [pidbb_pkg::ERR_W-1:0]   diff_s1;

	// Stage 2: derivative, proportional product and zone flags
	logic                                 valid_s2;
	pidbb_pkg::law_in_t                   law_in_s2;

	// Output register
	logic                                 out_valid_q;
	logic [pidbb_pkg::DRIVE_W-1:0]        drive_q;
	pidbb_pkg::region_t                   region_q;

	logic                                 in_fire;
	logic                                 s1_go;
	logic                                 s2_go;
	logic                                 out_fire;
	logic signed [pidbb_pkg::ERR_W-1:0]   err_in;
	logic signed [pidbb_pkg::ERR_W-1:0]   diff_in;
	logic signed [pidbb_pkg::ERR_W-1:0]   range_w;
	logic signed [pidbb_pkg::GAIN_W:0]    prop_w;
	logic signed [pidbb_pkg::ACC_W-1:0]   deriv_next;
	pidbb_pkg::law_in_t                   law_in_next;
	pidbb_pkg::law_out_t                  law_res;

	// Handshake: each stage moves on when the one after it is empty or leaving,
	// so a waiting result never blocks the stages behind it from filling.
	assign out_fire = out_valid_q & out_ready;
	assign s2_go    = valid_s2 & (~out_valid_q | out_ready);
	assign s1_go    = valid_s1 & (~valid_s2 | s2_go);
	assign in_ready = ~valid_s1 | s1_go;
	assign in_fire  = in_valid & in_ready;

	// Error is target minus measurement, one bit wider than the sample
	always_comb begin
		err_in  = pidbb_pkg::ERR_W'(target_q) - pidbb_pkg::ERR_W'(measured_temp);
		diff_in = pidbb_pkg::ERR_W'(measured_temp) - pidbb_pkg::ERR_W'(prev_temp_q);
		range_w = $signed({2'b00, range_q});
		prop_w  = $signed({1'b0, prop_gain_q});
	end

	pidbb_deriv u_deriv (
		.deriv_gain_scaled (deriv_gain_q),
		.deriv_smoothing   (deriv_smooth_q),
		.diff              (diff_s1),
		.d_prev            (deriv_q),
		.d_next            (deriv_next)
	);

	// Zone decision and the proportional product are settled a stage early
	always_comb begin
		law_in_next.err      = err_s1;
		law_in_next.pe       = prop_w * err_s1;
		law_in_next.d        = deriv_next;
		law_in_next.far_high = err_s1 > range_w;
		law_in_next.far_low  = err_s1 < -range_w;
	end

	pidbb_law u_law (
		.req        (law_in_s2),
		.integral   (integral_q),
		.reentry    (reentry_q),
		.integ_gain (integ_gain_q),
		.full_drive (full_drive_q),
		.drive_max  (drive_max_q),
		.res        (law_res)
	);

	// Configuration writes: take effect at once; the user writes only while idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			deriv_smooth_q <= '0;
			target_q       <= '0;
			range_q        <= pidbb_pkg::RANGE_W'(160);
			full_drive_q   <= '1;
			drive_max_q    <= '1;
		end else if (cfg_we) begin
			case (pidbb_pkg::cfg_idx_t'(cfg_index))
				pidbb_pkg::CFG_PROP_GAIN:    prop_gain_q    <= cfg_data;
				pidbb_pkg::CFG_INTEG_GAIN:   integ_gain_q   <= cfg_data;
				pidbb_pkg::CFG_DERIV_GAIN:   deriv_gain_q   <= cfg_data;
				pidbb_pkg::CFG_DERIV_SMOOTH: deriv_smooth_q <= cfg_data;
				pidbb_pkg::CFG_TARGET_TEMP:  target_q       <= $signed(cfg_data);
				pidbb_pkg::CFG_FUNC_RANGE:   range_q        <= cfg_data[pidbb_pkg::RANGE_W-1:0];
				pidbb_pkg::CFG_FULL_DRIVE:   full_drive_q   <= cfg_data[pidbb_pkg::DRIVE_W-1:0];
				pidbb_pkg::CFG_DRIVE_MAX:    drive_max_q    <= cfg_data[pidbb_pkg::DRIVE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Stage valid bits and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			prev_temp_q <= '0;
			deriv_q     <= '0;
			integral_q  <= '0;
			reentry_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1    <= 1'b1;
				prev_temp_q <= measured_temp;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end

			// Advance the derivative as the request leaves stage 1
			if (s1_go) begin
				valid_s2 <= 1'b1;
				deriv_q  <= deriv_next;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end

			// Commit the integral and re-entry flag as the result is registered
			if (s2_go) begin
				out_valid_q <= 1'b1;
				integral_q  <= law_res.integral;
				reentry_q   <= law_res.reentry;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold while the next stage is busy
	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_s1  <= err_in;
			diff_s1 <= diff_in;
		end
		if (s1_go) begin
			law_in_s2 <= law_in_next;
		end
		if (s2_go) begin
			drive_q  <= law_res.drive;
			region_q <= law_res.region;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign region    = region_q;

endmodule
